FILE: src/point_in_polygon_test_assert.svh
// Assertion macros for the point-in-polygon block.
// Included by modules that carry concurrent checks; they expect clk and rst_n in scope.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// same-cycle implication
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pip_pkg.sv
// Shared types, codes and microcode ROM for the point-in-polygon block.
// No dependencies; used by the interfaces, sequencer, datapath and top level.
package pip_pkg;

  localparam int VIDX_W       = 4;  // vertex_index field
  localparam int VCNT_W       = 5;  // vertex_count register
  localparam int CCNT_W       = 5;  // crossing_count field
  localparam int MIN_VERTICES = 3;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  typedef logic [1:0] ptr_op_t;
  localparam ptr_op_t PTR_HOLD = 2'd0;
  localparam ptr_op_t PTR_CLR  = 2'd1;
  localparam ptr_op_t PTR_INC  = 2'd2;

  typedef logic [2:0] dp_op_t;
  localparam dp_op_t OP_NONE  = 3'd0;
  localparam dp_op_t OP_FIRST = 3'd1;
  localparam dp_op_t OP_SETUP = 3'd2;
  localparam dp_op_t OP_MUL   = 3'd3;
  localparam dp_op_t OP_ACC   = 3'd4;
  localparam dp_op_t OP_EMIT  = 3'd5;

  typedef logic [2:0] jmp_t;
  localparam jmp_t J_NEXT    = 3'd0;  // fall through
  localparam jmp_t J_START   = 3'd1;  // to target on query, else hold
  localparam jmp_t J_DECIDED = 3'd2;  // to target when edge is settled without multiply
  localparam jmp_t J_MORE    = 3'd3;  // to target while edges remain
  localparam jmp_t J_OUTFREE = 3'd4;  // to target when result register free, else hold

  localparam upc_t U_IDLE  = 3'd0;
  localparam upc_t U_FIRST = 3'd1;
  localparam upc_t U_SETUP = 3'd2;
  localparam upc_t U_MUL   = 3'd3;
  localparam upc_t U_ACC   = 3'd4;
  localparam upc_t U_EMIT  = 3'd5;

  typedef struct packed {
    logic    rd_en;
    ptr_op_t ptr_op;
    dp_op_t  dp_op;
    jmp_t    jmp;
    upc_t    target;
  } ucode_t;

  // sequencer -> datapath
  typedef struct packed {
    dp_op_t op;
    logic   last;   // closing edge, second vertex is vertex zero
  } dp_ctrl_t;

  // conditions seen by the sequencer
  typedef struct packed {
    logic start;
    logic decided;
    logic out_free;
  } seq_stat_t;

  function automatic ucode_t ucode_rom(input upc_t upc);
    ucode_t w;
    unique case (upc)
      U_IDLE:  w = '{rd_en: 1'b1, ptr_op: PTR_CLR,  dp_op: OP_NONE,  jmp: J_START,
                     target: U_FIRST};
      U_FIRST: w = '{rd_en: 1'b1, ptr_op: PTR_INC,  dp_op: OP_FIRST, jmp: J_NEXT,
                     target: U_SETUP};
      U_SETUP: w = '{rd_en: 1'b0, ptr_op: PTR_HOLD, dp_op: OP_SETUP, jmp: J_DECIDED,
                     target: U_ACC};
      U_MUL:   w = '{rd_en: 1'b0, ptr_op: PTR_HOLD, dp_op: OP_MUL,   jmp: J_NEXT,
                     target: U_ACC};
      U_ACC:   w = '{rd_en: 1'b1, ptr_op: PTR_INC,  dp_op: OP_ACC,   jmp: J_MORE,
                     target: U_SETUP};
      U_EMIT:  w = '{rd_en: 1'b0, ptr_op: PTR_HOLD, dp_op: OP_EMIT,  jmp: J_OUTFREE,
                     target: U_IDLE};
      default: w = '{rd_en: 1'b0, ptr_op: PTR_CLR,  dp_op: OP_NONE,  jmp: J_NEXT,
                     target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: src/pip_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on pip_pkg for field widths.
interface pip_req_if #(parameter int COORD_BITS = 16);
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [pip_pkg::VIDX_W-1:0]       vertex_index;
  logic signed [COORD_BITS-1:0]     coord_x;
  logic signed [COORD_BITS-1:0]     coord_y;

  modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_res_if;
  logic                         valid;
  logic                         ready;
  logic                         inside_res;
  logic [pip_pkg::CCNT_W-1:0]   crossing_count;

  modport source (output valid, inside_res, crossing_count, input ready);
  modport sink   (input valid, inside_res, crossing_count, output ready);
endinterface

interface pip_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pip_pkg::VCNT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/pip_vtx_mem.sv
// Vertex table: one write port, one read port with registered read data.
// Each entry holds {x, y}; no dependencies.
module pip_vtx_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/pip_dpath.sv
// Edge-evaluation datapath: orders an edge, decides it by sign where it can,
// otherwise compares two products; keeps the crossing count. Depends on pip_pkg.
module pip_dpath #(
  parameter int COORD_BITS   = 16,
  parameter int MAX_VERTICES = 16,
  localparam int CB   = COORD_BITS,
  localparam int CNTW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                    clk,
  input  pip_pkg::dp_ctrl_t       ctrl,
  input  logic                    q_load,
  input  logic signed [CB-1:0]    q_x,
  input  logic signed [CB-1:0]    q_y,
  input  logic [2*CB-1:0]         rd_data,
  output logic                    decided,
  output logic [CNTW-1:0]         cnt
);

  logic signed [CB-1:0] px_r, py_r;
  logic signed [CB-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                 skip_r, triv_r, tval_r, dneg_r;
  logic [CB-1:0]        mag_r, t_r, dy_r;
  logic [CB:0]          msel_r;
  logic [2*CB-1:0]      p1_r;
  logic [2*CB:0]        p2_r;
  logic [CNTW-1:0]      cnt_r;

  logic signed [CB-1:0] rd_x, rd_y, bx, by, lo_x, lo_y, hi_x, hi_y;
  logic signed [CB:0]   dx, dyw, tw, dd, dx_neg;
  logic signed [CB+1:0] e1;
  logic                 horiz, swap, in_rng, skip_c, triv_c, dneg_c;
  logic [CB-1:0]        mag_c, t_c, dy_c;
  logic [CB:0]          msel_c;
  logic                 hit;

  assign rd_x = rd_data[2*CB-1:CB];
  assign rd_y = rd_data[CB-1:0];

  always_comb begin
    bx     = ctrl.last ? first_x_r : rd_x;
    by     = ctrl.last ? first_y_r : rd_y;
    horiz  = (prev_y_r == by);
    swap   = (prev_y_r > by);
    lo_x   = swap ? bx : prev_x_r;
    lo_y   = swap ? by : prev_y_r;
    hi_x   = swap ? prev_x_r : bx;
    hi_y   = swap ? prev_y_r : by;
    in_rng = (py_r >= lo_y) && (py_r < hi_y);
    skip_c = horiz || !in_rng;

    dx     = (CB+1)'(hi_x) - (CB+1)'(lo_x);
    dx_neg = -dx;
    dyw    = (CB+1)'(hi_y) - (CB+1)'(lo_y);
    tw     = (CB+1)'(py_r) - (CB+1)'(lo_y);
    dd     = (CB+1)'(px_r) - (CB+1)'(lo_x);
    e1     = (CB+2)'(1) - (CB+2)'(dd);
    dneg_c = dx[CB];
    mag_c  = dneg_c ? CB'(dx_neg) : CB'(dx);
    dy_c   = CB'(dyw);
    t_c    = CB'(tw);
    // rising x: crossing iff mag*t >= d*dy (trivially true for d <= 0)
    // falling x: crossing iff mag*t < (1-d)*dy (trivially false for d > 0)
    triv_c = dneg_c ? (dd > 0) : (dd <= 0);
    msel_c = dneg_c ? (CB+1)'(e1) : (CB+1)'(dd);
  end

  assign decided = skip_c || triv_c;

  always_comb begin
    if (skip_r) begin
      hit = 1'b0;
    end else if (triv_r) begin
      hit = tval_r;
    end else if (dneg_r) begin
      hit = ({1'b0, p1_r} < p2_r);
    end else begin
      hit = ({1'b0, p1_r} >= p2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (q_load) begin
      px_r <= q_x;
      py_r <= q_y;
    end
    case (ctrl.op)
      pip_pkg::OP_FIRST: begin
        first_x_r <= rd_x;
        first_y_r <= rd_y;
        prev_x_r  <= rd_x;
        prev_y_r  <= rd_y;
        cnt_r     <= '0;
      end
      pip_pkg::OP_SETUP: begin
        prev_x_r <= bx;
        prev_y_r <= by;
        skip_r   <= skip_c;
        triv_r   <= triv_c;
        tval_r   <= !dneg_c;
        dneg_r   <= dneg_c;
        mag_r    <= mag_c;
        t_r      <= t_c;
        dy_r     <= dy_c;
        msel_r   <= msel_c;
      end
      pip_pkg::OP_MUL: begin
        p1_r <= mag_r * t_r;
        p2_r <= msel_r * dy_r;
      end
      pip_pkg::OP_ACC: begin
        cnt_r <= cnt_r + CNTW'(hit);
      end
      default: begin
      end
    endcase
  end

  assign cnt = cnt_r;

endmodule

FILE: src/pip_useq.sv
// Microcoded sequencer: program counter over the ROM in pip_pkg, vertex pointer,
// conditional jumps and vertex-table read control. Depends on pip_pkg.
module pip_useq #(
  parameter int MAX_VERTICES = 16,
  localparam int IW = $clog2(MAX_VERTICES),
  localparam int PW = $clog2(MAX_VERTICES + 2)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pip_pkg::VCNT_W-1:0]  vertex_count,
  input  pip_pkg::seq_stat_t          stat,
  output pip_pkg::dp_ctrl_t           dp_ctrl,
  output logic                        rd_en,
  output logic [IW-1:0]               rd_addr,
  output logic                        idle,
  output logic                        emit
);

  localparam int VCW = pip_pkg::VCNT_W;

  pip_pkg::upc_t   upc_r, upc_nxt, upc_inc;
  logic [PW-1:0]   ptr_r, ptr_nxt, n_eff;
  pip_pkg::ucode_t uw;

  assign uw      = pip_pkg::ucode_rom(upc_r);
  assign upc_inc = upc_r + pip_pkg::upc_t'(1);

  // vertex count clamped to the supported range
  always_comb begin
    if (vertex_count < VCW'(pip_pkg::MIN_VERTICES)) begin
      n_eff = PW'(pip_pkg::MIN_VERTICES);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_eff = PW'(MAX_VERTICES);
    end else begin
      n_eff = PW'(vertex_count);
    end
  end

  always_comb begin
    unique case (uw.ptr_op)
      pip_pkg::PTR_CLR: ptr_nxt = '0;
      pip_pkg::PTR_INC: ptr_nxt = ptr_r + PW'(1);
      default:          ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    unique case (uw.jmp)
      pip_pkg::J_NEXT:    upc_nxt = upc_inc;
      pip_pkg::J_START:   upc_nxt = stat.start ? uw.target : upc_r;
      pip_pkg::J_DECIDED: upc_nxt = stat.decided ? uw.target : upc_inc;
      pip_pkg::J_MORE:    upc_nxt = (ptr_r != n_eff) ? uw.target : upc_inc;
      pip_pkg::J_OUTFREE: upc_nxt = stat.out_free ? uw.target : upc_r;
      default:            upc_nxt = pip_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= pip_pkg::U_IDLE;
      ptr_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // the closing edge takes vertex zero from the datapath, no fetch needed
  assign rd_en        = uw.rd_en && (ptr_nxt < n_eff);
  assign rd_addr      = IW'(ptr_nxt);
  assign dp_ctrl.op   = uw.dp_op;
  assign dp_ctrl.last = (ptr_r == n_eff);
  assign idle         = (upc_r == pip_pkg::U_IDLE);
  assign emit         = (uw.dp_op == pip_pkg::OP_EMIT) && stat.out_free;

endmodule

FILE: src/point_in_polygon_test.sv
// Even-odd point-in-polygon test. A load transaction (req_type 0) writes one vertex
// into the table and returns nothing; slots at or above MAX_VERTICES are dropped.
// A query transaction (req_type 1) walks the N closed edges, N being vertex_count
// clamped to 3..MAX_VERTICES, one edge per pass of a microcoded loop: setup,
// multiply, accumulate, where an edge that is horizontal, out of y range or settled
// by sign skips the multiply. A query keeps the block busy through that loop and its
// one multiplier pair; the result then waits in an output register. Requests are
// taken only while the sequencer is idle. Vertices must be loaded before a query
// reads them; there is no clearing pass.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pip_req_if.sink   in_req,
  pip_res_if.source out_res,
  pip_cfg_if.sink   cfg_wr
);

  `include "point_in_polygon_test_assert.svh"

  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int CCW  = pip_pkg::CCNT_W;
  localparam int VCW  = pip_pkg::VCNT_W;

  logic [VCW-1:0]        vertex_count_r;
  logic                  out_valid_r;
  logic                  out_inside_r;
  logic [CCW-1:0]        out_count_r;

  logic                  in_acc, query_acc, vtx_wr_en;
  logic                  seq_idle, seq_emit, mem_rd_en;
  logic [IW-1:0]         mem_rd_addr;
  logic [2*COORD_BITS-1:0] mem_rd_data;
  logic [CNTW-1:0]       cnt;
  logic                  dp_decided;
  pip_pkg::dp_ctrl_t     dp_ctrl;
  pip_pkg::seq_stat_t    stat;

  assign in_req.ready = seq_idle;
  assign cfg_wr.ready = 1'b1;
  assign in_acc       = in_req.valid && in_req.ready;
  assign query_acc    = in_acc && (in_req.req_type == pip_pkg::REQ_QUERY);
  assign vtx_wr_en    = in_acc && (in_req.req_type == pip_pkg::REQ_LOAD)
                        && (32'(in_req.vertex_index) < MAX_VERTICES);

  assign stat.start    = query_acc;
  assign stat.decided  = dp_decided;
  assign stat.out_free = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCW'(pip_pkg::MIN_VERTICES);
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      vertex_count_r <= cfg_wr.data;
    end
  end

  pip_vtx_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (IW),
    .DW    (2 * COORD_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (vtx_wr_en),
    .wr_addr (IW'(in_req.vertex_index)),
    .wr_data ({in_req.coord_x, in_req.coord_y}),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  pip_useq #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_count (vertex_count_r),
    .stat         (stat),
    .dp_ctrl      (dp_ctrl),
    .rd_en        (mem_rd_en),
    .rd_addr      (mem_rd_addr),
    .idle         (seq_idle),
    .emit         (seq_emit)
  );

  pip_dpath #(
    .COORD_BITS   (COORD_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk     (clk),
    .ctrl    (dp_ctrl),
    .q_load  (query_acc),
    .q_x     (in_req.coord_x),
    .q_y     (in_req.coord_y),
    .rd_data (mem_rd_data),
    .decided (dp_decided),
    .cnt     (cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_emit) begin
      out_inside_r <= cnt[0];
      out_count_r  <= CCW'(cnt);
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.inside_res     = out_inside_r;
  assign out_res.crossing_count = out_count_r;

  `PIP_ASSERT_IMP(a_emit_when_free, seq_emit, !out_valid_r || out_res.ready, "result overwrote a pending one")
  `PIP_ASSERT_NXT(a_query_starts, query_acc, !seq_idle, "accepted query did not start the sequencer")
  `PIP_ASSERT_NXT(a_emit_to_idle, seq_emit, seq_idle, "sequencer did not return to idle after a result")

endmodule
